FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stencil block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hdbs_pkg.sv
// ----------------------------------------------------------------------------
// hdbs_pkg
// Types and constants shared by the burn and diffusion stencil modules.
// ----------------------------------------------------------------------------
package hdbs_pkg;

  localparam int GEOM_W     = 10;
  localparam int GEOM_MIN   = 3;
  localparam int CFG_IDX_W  = 3;

  localparam int GRID_COLS_RESET          = 350;
  localparam int GRID_ROWS_RESET          = 350;
  localparam logic [31:0] IGNITION_RESET  = 32'd7680;
  localparam logic [15:0] BURN_RESET      = 16'd45875;
  localparam logic [15:0] DIFFUSION_RESET = 16'd52429;

  // 1.0 in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic {
    OP_CELL  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS          = 3'd0,
    REG_GRID_ROWS          = 3'd1,
    REG_IGNITION_THRESHOLD = 3'd2,
    REG_BURN_FRACTION      = 3'd3,
    REG_DIFFUSION_RATE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] cell_temperature;
    logic [31:0] cell_fuel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_temperature;
    logic [31:0] new_fuel;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] fuel;
    logic [31:0] temp;
  } cell_t;

  // One line memory entry: two rows of the same column
  typedef struct packed {
    cell_t upper;
    cell_t lower;
  } line_t;

  // Decision taken when an item is accepted
  typedef struct packed {
    logic  is_cell;
    logic  emit;
    logic  border;
    logic  last;
    logic  sel_upper;
    cell_t data;
  } front_t;

  // Item leaving the memory stage
  typedef struct packed {
    logic  is_cell;
    logic  emit;
    logic  border;
    logic  last;
    logic  sel_upper;
    cell_t data;
    line_t line;
  } s1_t;

  // Item leaving the window stage
  typedef struct packed {
    logic        border;
    logic        last;
    logic        burn;
    cell_t       center;
    logic [34:0] sum;
  } win_out_t;

endpackage

FILE: rtl/heat_diffusion_burn_stencil.sv
// ----------------------------------------------------------------------------
// heat_diffusion_burn_stencil
// One generation of a burning grid over a raster stream of cells: 3x3
// diffusion for cool cells, fuel burn for hot ones, borders passed through.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake                    Payload
// cell      in    cell_valid / cell_ready      cell_item   (in_item_t)
// result    out   result_valid / result_ready  result_item (out_item_t)
// cfg       in    cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One item per cycle sustained unless stalled results back up; the single
// read port of the line memory takes at most one access per item, a
// column for a cell or the pending column for a flush. A result passes the
// memory read, window and sum, products and output registers in turn.
// Reset clears counters, window and stage valids; the line memory has no
// clearing pass and is ready at once. A stalled result backs the stages up
// one by one; cell_ready drops only when the memory stage cannot move.
// Writing grid_cols or grid_rows restarts the frame counters.
//
module heat_diffusion_burn_stencil #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cell_valid,
  output logic                               cell_ready,
  input  hdbs_pkg::in_item_t                 cell_item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output hdbs_pkg::out_item_t                result_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hdbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import hdbs_pkg::*;

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CXW = (CW > GEOM_W) ? CW : GEOM_W;
  localparam int RXW = (RW > GEOM_W) ? RW : GEOM_W;
  localparam int COLS_RST = (GRID_COLS_RESET > MAX_COLS) ? MAX_COLS : GRID_COLS_RESET;
  localparam int ROWS_RST = (GRID_ROWS_RESET > MAX_ROWS) ? MAX_ROWS : GRID_ROWS_RESET;

  // Configuration, geometry held already clamped
  logic [CW-1:0]  cols, cols_next;
  logic [RW-1:0]  rows, rows_next;
  logic [31:0]    threshold;
  logic [15:0]    burn_fraction, diffusion_rate;
  logic [CXW-1:0] gc;
  logic [RXW-1:0] gr;
  logic           cfg_write, restart;

  // Stage flow
  logic           accept, load_s1, s1_valid, s1_adv, s2_valid, s2_adv, s3_valid;
  logic           out_free, s3_free, s2_free;
  logic [AW-1:0]  addr;
  front_t         tag;
  s1_t            s1;
  win_out_t       s2;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    gc = CXW'(cfg_data[GEOM_W-1:0]);
    gr = RXW'(cfg_data[GEOM_W-1:0]);
    if (gc < CXW'(GEOM_MIN)) begin
      cols_next = CW'(GEOM_MIN);
    end else if (gc > CXW'(MAX_COLS)) begin
      cols_next = CW'(MAX_COLS);
    end else begin
      cols_next = CW'(gc);
    end
    if (gr < RXW'(GEOM_MIN)) begin
      rows_next = RW'(GEOM_MIN);
    end else if (gr > RXW'(MAX_ROWS)) begin
      rows_next = RW'(MAX_ROWS);
    end else begin
      rows_next = RW'(gr);
    end
  end

  // Decode the register index; unknown indexes drop the write
  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_COLS, REG_GRID_ROWS: restart = 1'b1;
        default:                      restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols           <= CW'(COLS_RST);
      rows           <= RW'(ROWS_RST);
      threshold      <= IGNITION_RESET;
      burn_fraction  <= BURN_RESET;
      diffusion_rate <= DIFFUSION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_COLS:          cols           <= cols_next;
        REG_GRID_ROWS:          rows           <= rows_next;
        REG_IGNITION_THRESHOLD: threshold      <= cfg_data;
        REG_BURN_FRACTION:      burn_fraction  <= cfg_data[15:0];
        REG_DIFFUSION_RATE:     diffusion_rate <= cfg_data[15:0];
        default:                ;
      endcase
    end
  end

  // Advance a stage when the one after it is empty or moving on
  always_comb begin
    out_free   = !result_valid || result_ready;
    s3_free    = !s3_valid || out_free;
    s2_free    = !s2_valid || s3_free;
    s2_adv     = s2_valid && s3_free;
    s1_adv     = s1_valid && s2_free;
    cell_ready = !s1_valid || s2_free;
    accept     = cell_valid && cell_ready;
    // Flush items with nothing to release stop here
    load_s1    = accept && (tag.is_cell || tag.emit);
  end

  hdbs_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .cols    (cols),
    .rows    (rows),
    .accept  (accept),
    .item    (cell_item),
    .addr    (addr),
    .tag     (tag)
  );

  hdbs_line_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_line_mem (
    .clk      (clk),
    .rst      (rst),
    .load     (load_s1),
    .addr     (addr),
    .tag      (tag),
    .adv      (s1_adv),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  hdbs_window u_window (
    .clk       (clk),
    .rst       (rst),
    .s1_adv    (s1_adv),
    .s1        (s1),
    .threshold (threshold),
    .s3_free   (s3_free),
    .s2_valid  (s2_valid),
    .s2        (s2)
  );

  hdbs_update u_update (
    .clk            (clk),
    .rst            (rst),
    .load           (s2_adv),
    .s2             (s2),
    .burn_fraction  (burn_fraction),
    .diffusion_rate (diffusion_rate),
    .s3_valid       (s3_valid),
    .result_ready   (result_ready),
    .result_valid   (result_valid),
    .result_item    (result_item)
  );

endmodule

FILE: rtl/hdbs_seq.sv
// ----------------------------------------------------------------------------
// hdbs_seq
// Raster counters and result scheduling for accepted items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbs_seq #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic [$clog2(MAX_COLS+1)-1:0]   cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]   rows,
  input  logic                            accept,
  input  hdbs_pkg::in_item_t              item,
  output logic [$clog2(MAX_COLS)-1:0]     addr,
  output hdbs_pkg::front_t                tag
);
  import hdbs_pkg::*;

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RAW = $clog2(MAX_ROWS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int LW  = $clog2(MAX_COLS + 3);

  logic [AW-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [RAW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [LW-1:0]  lag, lag_next;
  logic           is_cell, at_full, border, last, emit;
  logic           in_col_end, in_row_end, out_col_end, out_row_end;

  always_comb begin
    is_cell     = (item.op == OP_CELL);
    in_col_end  = (CW'(in_col) + CW'(1)) == cols;
    in_row_end  = (RW'(in_row) + RW'(1)) == rows;
    out_col_end = (CW'(out_col) + CW'(1)) == cols;
    out_row_end = (RW'(out_row) + RW'(1)) == rows;
    at_full     = lag >= (LW'(cols) + LW'(1));
    border      = (out_row == '0) || out_row_end || (out_col == '0) || out_col_end;
    last        = out_row_end && out_col_end;
    emit        = is_cell ? at_full : ((lag != '0) && border);
  end

  always_comb begin
    addr          = is_cell ? in_col : out_col;
    tag.is_cell   = is_cell;
    tag.emit      = emit;
    tag.border    = border;
    tag.last      = last;
    tag.sel_upper = at_full;
    tag.data.temp = item.cell_temperature;
    tag.data.fuel = item.cell_fuel;
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    lag_next     = lag;
    if (accept && is_cell) begin
      if (in_col_end) begin
        in_col_next = '0;
        in_row_next = in_row_end ? '0 : in_row + RAW'(1);
      end else begin
        in_col_next = in_col + AW'(1);
      end
      if (!at_full) begin
        lag_next = lag + LW'(1);
      end
    end else if (accept && emit) begin
      lag_next = lag - LW'(1);
    end
    if (accept && emit) begin
      if (out_col_end) begin
        out_col_next = '0;
        out_row_next = out_row_end ? '0 : out_row + RAW'(1);
      end else begin
        out_col_next = out_col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lag     <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      lag     <= lag_next;
    end
  end

  // Pending distance never passes one row plus one cell
  `ASSERT_ALWAYS(a_lag_bound, clk, rst, lag <= (LW'(cols) + LW'(1)), "lag beyond one row")

endmodule

FILE: rtl/hdbs_line_mem.sv
// ----------------------------------------------------------------------------
// hdbs_line_mem
// Two-row line memory with registered read and write-back forwarding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbs_line_mem #(
  parameter int MAX_COLS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [$clog2(MAX_COLS)-1:0] addr,
  input  hdbs_pkg::front_t            tag,
  input  logic                        adv,
  output logic                        s1_valid,
  output hdbs_pkg::s1_t               s1
);
  import hdbs_pkg::*;

  localparam int AW = $clog2(MAX_COLS);

  line_t          mem [MAX_COLS];
  line_t          rd;
  line_t          byp_line;
  line_t          eff;
  line_t          wr_line;
  logic           byp;
  logic [AW-1:0]  s1_col;
  front_t         tag_q;

  // Take the write-back of the item ahead when it hits the same column
  always_comb begin
    eff           = byp ? byp_line : rd;
    wr_line.upper = eff.lower;
    wr_line.lower = tag_q.data;
  end

  always_ff @(posedge clk) begin
    if (adv && tag_q.is_cell) begin
      mem[s1_col] <= wr_line;
    end
    if (load) begin
      rd <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_col   <= addr;
      tag_q    <= tag;
      byp      <= s1_valid && adv && tag_q.is_cell && (s1_col == addr);
      byp_line <= wr_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    s1.is_cell   = tag_q.is_cell;
    s1.emit      = tag_q.emit;
    s1.border    = tag_q.border;
    s1.last      = tag_q.last;
    s1.sel_upper = tag_q.sel_upper;
    s1.data      = tag_q.data;
    s1.line      = eff;
  end

  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !adv, s1_valid, "memory stage item lost")

endmodule

FILE: rtl/hdbs_window.sv
// ----------------------------------------------------------------------------
// hdbs_window
// 3x3 temperature window, centre fuel and neighbour sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbs_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_adv,
  input  hdbs_pkg::s1_t       s1,
  input  logic [31:0]         threshold,
  input  logic                s3_free,
  output logic                s2_valid,
  output hdbs_pkg::win_out_t  s2
);
  import hdbs_pkg::*;

  logic [31:0] win [9];
  logic [31:0] win_next [9];
  logic [31:0] cfuel [3];
  logic [31:0] cfuel_next [3];
  logic [32:0] sa, sb, sc, sd;
  logic [33:0] se, sf;
  logic [34:0] sum_next;
  logic        shift;

  always_comb begin
    shift = s1_adv && s1.is_cell;
    for (int k = 0; k < 9; k++) begin
      win_next[k] = win[k];
    end
    for (int k = 0; k < 3; k++) begin
      cfuel_next[k] = cfuel[k];
    end
    if (shift) begin
      for (int k = 0; k < 3; k++) begin
        win_next[k*3]     = win[k*3+1];
        win_next[k*3 + 1] = win[k*3+2];
      end
      win_next[2]   = s1.line.upper.temp;
      win_next[5]   = s1.line.lower.temp;
      win_next[8]   = s1.data.temp;
      cfuel_next[0] = cfuel[1];
      cfuel_next[1] = cfuel[2];
      cfuel_next[2] = s1.line.lower.fuel;
    end
  end

  // Sum the eight neighbours of the new centre
  always_comb begin
    sa       = 33'(win_next[0]) + 33'(win_next[1]);
    sb       = 33'(win_next[2]) + 33'(win_next[3]);
    sc       = 33'(win_next[5]) + 33'(win_next[6]);
    sd       = 33'(win_next[7]) + 33'(win_next[8]);
    se       = 34'(sa) + 34'(sb);
    sf       = 34'(sc) + 34'(sd);
    sum_next = 35'(se) + 35'(sf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        cfuel[k] <= '0;
      end
    end else if (shift) begin
      win   <= win_next;
      cfuel <= cfuel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2.border <= s1.border;
      s2.last   <= s1.last;
      s2.burn   <= win_next[4] >= threshold;
      s2.sum    <= sum_next;
      if (s1.is_cell) begin
        s2.center.temp <= win_next[4];
        s2.center.fuel <= cfuel_next[1];
      end else begin
        s2.center <= s1.sel_upper ? s1.line.upper : s1.line.lower;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1.emit;
    end else if (s3_free) begin
      s2_valid <= 1'b0;
    end
  end

  // A held window stage item must see a frozen window
  `ASSERT_NEXT(a_win_frozen, clk, rst, s2_valid && !s3_free, $stable(win[4]) && $stable(cfuel[1]), "window moved under a held item")

endmodule

FILE: rtl/hdbs_update.sv
// ----------------------------------------------------------------------------
// hdbs_update
// Burn and diffusion arithmetic with the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdbs_update (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  hdbs_pkg::win_out_t   s2,
  input  logic [15:0]          burn_fraction,
  input  logic [15:0]          diffusion_rate,
  output logic                 s3_valid,
  input  logic                 result_ready,
  output logic                 result_valid,
  output hdbs_pkg::out_item_t  result_item
);
  import hdbs_pkg::*;

  logic        s3_adv;
  logic [16:0] keep_d, keep_b;
  logic [47:0] prod_bt;
  logic [48:0] prod_bf;
  logic        border, last, burn;
  cell_t       center;
  logic [31:0] burn_t, burn_f;
  logic [48:0] p_keep;
  logic [50:0] p_nb;
  logic [52:0] acc;
  logic [33:0] acc_sh;
  logic [31:0] diff_t;

  always_comb begin
    keep_d  = ONE_Q16 - 17'(diffusion_rate);
    keep_b  = ONE_Q16 - 17'(burn_fraction);
    prod_bt = 48'(s2.center.fuel) * 48'(burn_fraction);
    prod_bf = 49'(s2.center.fuel) * 49'(keep_b);
  end

  // Products stage
  always_ff @(posedge clk) begin
    if (load) begin
      border <= s2.border;
      last   <= s2.last;
      burn   <= s2.burn;
      center <= s2.center;
      burn_t <= prod_bt[47:16];
      burn_f <= prod_bf[47:16];
      p_keep <= 49'(s2.center.temp) * 49'(keep_d);
      p_nb   <= 51'(s2.sum) * 51'(diffusion_rate);
    end
  end

  always_comb begin
    s3_adv = s3_valid && (!result_valid || result_ready);
    acc    = 53'({p_keep, 3'b000}) + 53'(p_nb);
    acc_sh = acc[52:19];
    diff_t = (acc_sh[33:32] != 2'b00) ? '1 : acc_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      result_item.frame_last <= last;
      if (border) begin
        result_item.new_temperature <= center.temp;
        result_item.new_fuel        <= center.fuel;
      end else if (burn) begin
        result_item.new_temperature <= burn_t;
        result_item.new_fuel        <= burn_f;
      end else begin
        result_item.new_temperature <= diff_t;
        result_item.new_fuel        <= center.fuel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        s3_valid <= 1'b1;
      end else if (s3_adv) begin
        s3_valid <= 1'b0;
      end
      if (s3_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_s3_drains, clk, rst, s3_valid && !result_valid, result_valid, "product stage stuck with output free")

endmodule

FILE: verif/stencil_result_checker.sv
// ----------------------------------------------------------------------------
// stencil_result_checker
// Watches the cell, result and register channels of the burn stencil. Keeps
// its own copy of the line stores, window and counters, works out every
// next-generation cell the block owes and compares the results field by field.
// ----------------------------------------------------------------------------
module stencil_result_checker #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cell_valid,
  input  logic                           cell_ready,
  input  hdbs_pkg::in_item_t             cell_item,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  hdbs_pkg::out_item_t            result_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hdbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             failures,
  output int                             outstanding,
  output int                             results_checked,
  output int                             burnt_cells,
  output int                             diffused_cells
);

  import hdbs_pkg::*;

  cell_t             row_far  [MAX_COLS];   // two rows back, per column
  cell_t             row_near [MAX_COLS];   // one row back, per column
  logic [31:0]       win_temp [9];
  logic [31:0]       win_fuel [3];
  int unsigned       in_row, in_col, out_row, out_col;
  logic [GEOM_W-1:0] cols_reg, rows_reg;
  logic [31:0]       ignite_at;
  logic [15:0]       burn_share, heat_share;
  out_item_t         due_results [$];
  int                n_fail, n_checked, n_burnt, n_diffused;

  function automatic int unsigned clamp_dim(logic [GEOM_W-1:0] v, int unsigned hi);
    if (v < GEOM_MIN) return GEOM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // distance in raster order from the next result owed to the next cell taken
  function automatic int unsigned cells_behind(int unsigned cols, int unsigned rows);
    int unsigned n, i, o;
    n = cols * rows;
    i = (in_row * cols + in_col) % n;
    o = (out_row * cols + out_col) % n;
    return (i + n - o) % n;
  endfunction

  function automatic bit out_on_border(int unsigned cols, int unsigned rows);
    return out_row == 0 || out_row >= rows - 1 || out_col == 0 || out_col >= cols - 1;
  endfunction

  function automatic out_item_t next_generation(int unsigned cols, int unsigned rows,
                                                int unsigned lag);
    out_item_t   res;
    cell_t       kept;
    logic [63:0] prod, total, acc;
    res = '0;
    if (out_on_border(cols, rows)) begin
      kept = (lag >= cols + 1) ? row_far[out_col % cols] : row_near[out_col % cols];
      res.new_temperature = kept.temp;
      res.new_fuel        = kept.fuel;
    end else if (win_temp[4] >= ignite_at) begin
      prod = 64'(win_fuel[1]) * 64'(burn_share);
      res.new_temperature = prod[47:16];
      prod = 64'(win_fuel[1]) * (64'(ONE_Q16) - 64'(burn_share));
      res.new_fuel = prod[47:16];
      n_burnt++;
    end else begin
      total = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) total += 64'(win_temp[k]);
      end
      acc = 64'(win_temp[4]) * (64'(ONE_Q16) - 64'(heat_share)) * 64'd8
            + total * 64'(heat_share);
      acc = acc >> 19;
      res.new_temperature = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
      res.new_fuel = win_fuel[1];
      n_diffused++;
    end
    res.frame_last = (out_row == rows - 1) && (out_col == cols - 1);
    out_col++;
    if (out_col >= cols) begin
      out_col = 0;
      out_row++;
      if (out_row >= rows) out_row = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    int unsigned cols, rows, col, lag;
    cell_t       fresh, far, near;
    out_item_t   want;
    if (rst) begin
      for (int k = 0; k < MAX_COLS; k++) begin
        row_far[k]  = '0;
        row_near[k] = '0;
      end
      for (int k = 0; k < 9; k++) win_temp[k] = '0;
      for (int k = 0; k < 3; k++) win_fuel[k] = '0;
      in_row     = 0;
      in_col     = 0;
      out_row    = 0;
      out_col    = 0;
      cols_reg   = GEOM_W'(GRID_COLS_RESET);
      rows_reg   = GEOM_W'(GRID_ROWS_RESET);
      ignite_at  = IGNITION_RESET;
      burn_share = BURN_RESET;
      heat_share = DIFFUSION_RESET;
      due_results.delete();
      n_fail     = 0;
      n_checked  = 0;
      n_burnt    = 0;
      n_diffused = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing owed: new_temperature %h new_fuel %h",
                 result_item.new_temperature, result_item.new_fuel);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (result_item.new_temperature !== want.new_temperature) begin
            $error("new_temperature: expected %h, got %h",
                   want.new_temperature, result_item.new_temperature);
            n_fail++;
          end
          if (result_item.new_fuel !== want.new_fuel) begin
            $error("new_fuel: expected %h, got %h", want.new_fuel, result_item.new_fuel);
            n_fail++;
          end
          if (result_item.frame_last !== want.frame_last) begin
            $error("frame_last: expected %b, got %b",
                   want.frame_last, result_item.frame_last);
            n_fail++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_COLS:          cols_reg   = cfg_data[GEOM_W-1:0];
          REG_GRID_ROWS:          rows_reg   = cfg_data[GEOM_W-1:0];
          REG_IGNITION_THRESHOLD: ignite_at  = cfg_data;
          REG_BURN_FRACTION:      burn_share = cfg_data[15:0];
          REG_DIFFUSION_RATE:     heat_share = cfg_data[15:0];
          default: ;
        endcase
        if (cfg_index == REG_GRID_COLS || cfg_index == REG_GRID_ROWS) begin
          in_row  = 0;
          in_col  = 0;
          out_row = 0;
          out_col = 0;
        end
      end

      if (cell_valid && cell_ready) begin
        cols = clamp_dim(cols_reg, MAX_COLS);
        rows = clamp_dim(rows_reg, MAX_ROWS);
        if (cell_item.op == OP_CELL) begin
          col   = in_col % cols;
          fresh = {cell_item.cell_fuel, cell_item.cell_temperature};
          far   = row_far[col];
          near  = row_near[col];
          row_far[col]  = near;
          row_near[col] = fresh;
          for (int r = 0; r < 3; r++) begin
            win_temp[3*r]   = win_temp[3*r+1];
            win_temp[3*r+1] = win_temp[3*r+2];
          end
          win_temp[2] = far.temp;
          win_temp[5] = near.temp;
          win_temp[8] = fresh.temp;
          win_fuel[0] = win_fuel[1];
          win_fuel[1] = win_fuel[2];
          win_fuel[2] = near.fuel;
          in_col = col + 1;
          if (in_col >= cols) begin
            in_col = 0;
            in_row++;
            if (in_row >= rows) in_row = 0;
          end
          lag = cells_behind(cols, rows);
          if (lag == cols + 2) due_results.push_back(next_generation(cols, rows, lag));
        end else begin
          lag = cells_behind(cols, rows);
          if (lag != 0 && out_on_border(cols, rows))
            due_results.push_back(next_generation(cols, rows, lag));
        end
      end
    end
    failures        <= n_fail;
    outstanding     <= due_results.size();
    results_checked <= n_checked;
    burnt_cells     <= n_burnt;
    diffused_cells  <= n_diffused;
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raster frames of cells and flush steps into the burn stencil under
// changing grid sizes, thresholds and shares, with random gaps on the cell
// side and random back-pressure on the result side; a separate checker
// predicts each result and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  import hdbs_pkg::*;

  localparam int MAX_COLS      = 512;
  localparam int MAX_ROWS      = 512;
  localparam int RANDOM_CELLS  = 1400;
  // memory, window, product and output stages behind the handshake, plus margin
  localparam int SETTLE_CYCLES = 8;
  // first register index with nothing behind it
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG =
    CFG_IDX_W'(REG_DIFFUSION_RATE) + CFG_IDX_W'(1);

  logic                 clk;
  logic                 rst;
  logic                 cell_valid;
  logic                 cell_ready;
  in_item_t             cell_item;
  logic                 result_valid;
  logic                 result_ready;
  out_item_t            result_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int failures, outstanding, results_checked, burnt_cells, diffused_cells;

  // percentages of cycles in which the cell side idles / the result side stalls
  int idle_pct;
  int stall_pct;

  int          cells_sent;
  int          flushes_sent;
  int          writes_done;
  int unsigned cols_used;
  int unsigned rows_used;

  heat_diffusion_burn_stencil #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_item    (cell_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  stencil_result_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) grid_check (
    .clk             (clk),
    .rst             (rst),
    .cell_valid      (cell_valid),
    .cell_ready      (cell_ready),
    .cell_item       (cell_item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_item     (result_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .burnt_cells     (burnt_cells),
    .diffused_cells  (diffused_cells)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: hold ready low during reset, then stall at random at the
  // rate the current phase asks for.
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Hard stop: far beyond the slowest correct run, even with every item and
  // every result waiting out the heaviest idling.
  initial begin
    #(8_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned clamp_dim(logic [GEOM_W-1:0] v, int unsigned hi);
    if (v < GEOM_MIN) return GEOM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Temperatures, fuels and thresholds spread over every order of magnitude,
  // with both ends of the range turning up often.
  function automatic logic [31:0] spread_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  // Q0.16 share with random junk above bit 15, which the block must drop.
  function automatic logic [31:0] share_word();
    logic [15:0] share;
    case ($urandom_range(3))
      0:       share = '0;
      1:       share = '1;
      default: share = 16'($urandom_range(0, 65535));
    endcase
    return ($urandom() & 32'hFFFF_0000) | 32'(share);
  endfunction

  function automatic in_item_t make_item(op_t op, logic [31:0] temp, logic [31:0] fuel);
    in_item_t item;
    item.op               = op;
    item.cell_temperature = temp;
    item.cell_fuel        = fuel;
    return item;
  endfunction

  // Offer one item and hold it until taken. Valid is only dropped when the
  // sender idles, so back-to-back items keep it high without a glitch.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_item  <= item;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    if (item.op == OP_CELL) cells_sent++;
    else                    flushes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  // Junk above bit 9 must be ignored; the block clamps what is left.
  task automatic set_geometry(input logic [GEOM_W-1:0] cols, input logic [GEOM_W-1:0] rows);
    write_reg(REG_GRID_COLS, ($urandom() & 32'hFFFF_FC00) | 32'(cols));
    write_reg(REG_GRID_ROWS, ($urandom() & 32'hFFFF_FC00) | 32'(rows));
    cols_used = clamp_dim(cols, MAX_COLS);
    rows_used = clamp_dim(rows, MAX_ROWS);
  endtask

  // Drop valid, wait until every owed result has come back, then let the
  // pipeline empty of items that owed nothing.
  task automatic settle();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    int frames;
    int phase;

    rst          <= 1'b1;
    cell_valid   <= 1'b0;
    cell_item    <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    idle_pct     = 0;
    stall_pct    = 0;
    cells_sent   = 0;
    flushes_sent = 0;
    writes_done  = 0;
    cols_used    = GRID_COLS_RESET;
    rows_used    = GRID_ROWS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part -----------------------------------------------------
    // Smallest grid, reached through out-of-range sizes that clamp up to 3x3.
    // Only a centre at full scale burns, almost all of its fuel goes to heat, and a
    // cool centre takes its heat almost wholly from its neighbours.
    set_geometry(GEOM_W'(0), GEOM_W'(2));
    write_reg(REG_IGNITION_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_BURN_FRACTION, 32'hFFFF_FFFF);
    write_reg(REG_DIFFUSION_RATE, 32'h0000_FFFF);
    // a write to an index with no register behind it must change nothing
    write_reg(FIRST_SPARE_REG, 32'hFFFF_FFFF);

    // flush with nothing owed: no result
    send_item(make_item(OP_FLUSH, '1, '1));

    // burning frame: full-scale centre with full fuel, extremes around it
    for (int k = 0; k < 9; k++)
      send_item(make_item(OP_CELL, (k == 4 || k[0]) ? '1 : '0,
                          (k == 4 || k[1]) ? '1 : '0));
    // drain two pending border cells of it, the end of the middle row and the start of the last
    repeat (2) send_item(make_item(OP_FLUSH, '0, '0));

    // second frame straight after: pushes the rest of the first one out;
    // flushes land once on a pending border cell and once on the interior
    for (int k = 0; k < 9; k++) begin
      send_item(make_item(OP_CELL, (k == 4) ? '0 : '1, k[0] ? '0 : '1));
      if (k == 5 || k == 7) send_item(make_item(OP_FLUSH, $urandom(), $urandom()));
    end
    repeat (4) send_item(make_item(OP_FLUSH, $urandom(), $urandom()));

    // ---- random part -------------------------------------------------------
    // Mostly whole frames with random content, a little flush noise inside
    // them, sometimes a broken frame left hanging, sometimes a drain at the
    // end. Idling rotates through the phases.
    target = cells_sent + RANDOM_CELLS;
    phase  = 0;
    while (cells_sent < target) begin
      settle();
      case (phase % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 68; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase

      if (phase == 5) begin
        // Widest grid, reached from the top of the field: one partial frame
        // just past the first row, enough to use the far columns and emit
        // the first borders; the interior left pending is dropped later.
        set_geometry('1, '1);
        repeat (MAX_COLS + 20) send_item(make_item(OP_CELL, spread_value(), spread_value()));
        repeat (4) send_item(make_item(OP_FLUSH, $urandom(), $urandom()));
      end else begin
        if ($urandom_range(9) < 7)
          set_geometry(GEOM_W'($urandom_range(0, 10)), GEOM_W'($urandom_range(0, 7)));
        if ($urandom_range(3) != 0) write_reg(REG_IGNITION_THRESHOLD, spread_value());
        if ($urandom_range(3) != 0) write_reg(REG_BURN_FRACTION, share_word());
        if ($urandom_range(3) != 0) write_reg(REG_DIFFUSION_RATE, share_word());
        if ($urandom_range(7) == 0)
          write_reg(CFG_IDX_W'(FIRST_SPARE_REG + $urandom_range(0, 2)), $urandom());

        frames = $urandom_range(1, 3);
        repeat (frames * cols_used * rows_used) begin
          if ($urandom_range(99) < 8) send_item(make_item(OP_FLUSH, $urandom(), $urandom()));
          send_item(make_item(OP_CELL, spread_value(), spread_value()));
        end
        // broken frame: stop part-way through up to two rows
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 2 * cols_used))
            send_item(make_item(OP_CELL, spread_value(), spread_value()));
        // drain what the flushes can reach, or leave it for the next frame
        if ($urandom_range(2) != 0)
          repeat (cols_used + 2) send_item(make_item(OP_FLUSH, $urandom(), $urandom()));
      end
      phase++;
    end

    // ---- end of run --------------------------------------------------------
    settle();
    $display("run covered %0d cells and %0d flush steps over %0d register writes",
             cells_sent, flushes_sent, writes_done);
    $display("%0d results compared, %0d burning and %0d diffusing interior cells among them",
             results_checked, burnt_cells, diffused_cells);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
